@@ rtl/stepper_pulse_homing_controller_top_defines.svh @@
// Assertion macros for the stepper pulse and homing controller.
// Used by the top level; expects clk and rst_n in the calling scope.
`ifndef STEPPER_PULSE_HOMING_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_PULSE_HOMING_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPHC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sphc_pkg.sv @@
// Shared types, codes, widths and helper functions of the stepper controller.
// No dependencies; the design and testbench modules refer to it by scoped names.
package sphc_pkg;

    // Widths of the stored period and position.
    localparam int PERIOD_W  = 32;
    localparam int POS_W     = 32;
    localparam int ELAPSED_W = PERIOD_W + 1;

    // Field widths of items and registers.
    localparam int SPEED_W = 24;
    localparam int SPD_W   = 24;
    localparam int CAL_W   = 16;
    localparam int REG_W   = 32;
    localparam int OUT_POS_W = 32;

    // Period divider sizes: (1000000 << 16) needs 36 bits.
    localparam int PROD_W = SPEED_W + SPD_W;
    localparam int QUOT_W = 36;
    localparam int CNT_W  = $clog2(QUOT_W);
    localparam int CMP_W  = (QUOT_W > PERIOD_W) ? QUOT_W : PERIOD_W;
    localparam logic [QUOT_W-1:0] DIVIDEND = QUOT_W'(64'd1000000 << 16);

    typedef logic [PERIOD_W-1:0]  period_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [POS_W-1:0]     pos_t;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_SPEED = 2'd1,
        OP_SET_DIR   = 2'd2,
        OP_HOME      = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_STEPS_PER_DEG = 2'd0,
        REG_SWITCH_POS    = 2'd1,
        REG_CALIB_TARGET  = 2'd2,
        REG_CALIB_SPEED   = 2'd3
    } cfg_idx_t;

    // Homing phases.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_AIM    = 3'd1,
        PH_SEEK   = 3'd2,
        PH_LOAD   = 3'd3,
        PH_TARGET = 3'd4
    } phase_t;

    // Item sequencer states.
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_DIVIDE,
        SQ_WRITE
    } seq_state_t;

    // Period unit states.
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_LOOP,
        DV_FINISH
    } div_state_t;

    // Configuration registers.
    typedef struct packed {
        logic [SPD_W-1:0] steps_per_deg;
        logic [REG_W-1:0] switch_position;
        logic [REG_W-1:0] calib_target;
        logic [CAL_W-1:0] calib_speed;
    } cfg_t;

    // One input item.
    typedef struct packed {
        op_t                op;
        logic [SPEED_W-1:0] speed_cmd;
        logic               direction;
        logic               switch_level;
    } item_t;

    // One result item.
    typedef struct packed {
        logic                 step_pulse;
        logic                 dir_level;
        logic [OUT_POS_W-1:0] position;
        logic                 homing_active;
        logic                 homing_done;
    } result_t;

    // Motion status seen by the sequencer.
    typedef struct packed {
        logic active;
        logic aiming;
        logic homed;
    } status_t;

    // Sign-extend or truncate a 32-bit register value to the position width.
    function automatic pos_t pos_from32(input logic [REG_W-1:0] v);
        return POS_W'(signed'(v));
    endfunction

    // Direction toward the target; kept when already there.
    function automatic logic aim_dir(input pos_t p, input pos_t t, input logic d);
        logic r;
        r = d;
        if ($signed(p) > $signed(t))
            r = 1'b0;
        else if ($signed(p) < $signed(t))
            r = 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/sphc_period.sv @@
// Step period unit: one multiply, then a restoring divide one quotient bit a cycle.
// Depends on sphc_pkg.
module sphc_period (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sphc_pkg::SPEED_W-1:0]   mag,
    input  logic [sphc_pkg::SPD_W-1:0]     steps_per_deg,
    output logic                           done,
    output sphc_pkg::period_t              period
);

    sphc_pkg::div_state_t state_reg, state_next;

    logic [sphc_pkg::PROD_W-1:0] prod_reg;
    logic [sphc_pkg::PROD_W-1:0] rem_reg;
    logic [sphc_pkg::QUOT_W-1:0] quot_reg;
    logic [sphc_pkg::CNT_W-1:0]  cnt_reg;
    logic                        zero_reg;

    logic [sphc_pkg::PROD_W:0]   trial;
    logic                        fits;
    logic [sphc_pkg::CMP_W-1:0]  q_ext;
    logic [sphc_pkg::CMP_W-1:0]  pmax_ext;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sphc_pkg::DV_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and completion strobe.
    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            sphc_pkg::DV_IDLE:
            begin
                if (start)
                    state_next = sphc_pkg::DV_CHECK;
            end
            sphc_pkg::DV_CHECK:
            begin
                if (prod_reg == '0)
                    state_next = sphc_pkg::DV_FINISH;
                else
                    state_next = sphc_pkg::DV_LOOP;
            end
            sphc_pkg::DV_LOOP:
            begin
                if (cnt_reg == '0)
                    state_next = sphc_pkg::DV_FINISH;
            end
            sphc_pkg::DV_FINISH:
            begin
                done       = 1'b1;
                state_next = sphc_pkg::DV_IDLE;
            end
            default:
                state_next = sphc_pkg::DV_IDLE;
        endcase
    end

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign trial = {rem_reg, sphc_pkg::DIVIDEND[cnt_reg]};
    assign fits  = (trial >= {1'b0, prod_reg});

    // Product, remainder and quotient registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sphc_pkg::DV_IDLE:
            begin
                if (start)
                    prod_reg <= sphc_pkg::PROD_W'(mag) * sphc_pkg::PROD_W'(steps_per_deg);
            end
            sphc_pkg::DV_CHECK:
            begin
                rem_reg  <= '0;
                quot_reg <= '0;
                cnt_reg  <= sphc_pkg::CNT_W'(sphc_pkg::QUOT_W - 1);
                zero_reg <= (prod_reg == '0);
            end
            sphc_pkg::DV_LOOP:
            begin
                if (fits)
                    rem_reg <= sphc_pkg::PROD_W'(trial - {1'b0, prod_reg});
                else
                    rem_reg <= trial[sphc_pkg::PROD_W-1:0];
                quot_reg <= {quot_reg[sphc_pkg::QUOT_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Saturate to the period width; a nonzero product never gives period zero.
    assign q_ext    = sphc_pkg::CMP_W'(quot_reg);
    assign pmax_ext = sphc_pkg::CMP_W'({sphc_pkg::PERIOD_W{1'b1}});

    always_comb
    begin
        if (zero_reg)
            period = '0;
        else if (q_ext > pmax_ext)
            period = '1;
        else if (q_ext == '0)
            period = sphc_pkg::PERIOD_W'(1);
        else
            period = sphc_pkg::PERIOD_W'(q_ext);
    end

endmodule

@@ rtl/sphc_motion.sv @@
// Motion state: period, tick counter, position, direction and homing phases.
// Depends on sphc_pkg; state changes only on the commit strobe.
module sphc_motion (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                commit,
    input  sphc_pkg::item_t     item,
    input  sphc_pkg::period_t   new_period,
    input  sphc_pkg::cfg_t      cfg,
    output sphc_pkg::status_t   status,
    output sphc_pkg::result_t   result
);

    sphc_pkg::period_t  period_reg, period_next;
    sphc_pkg::elapsed_t elapsed_reg, elapsed_next;
    sphc_pkg::pos_t     pos_reg, pos_next;
    logic               dir_reg, dir_next;
    sphc_pkg::phase_t   phase_reg, phase_next;
    logic               homed_reg, homed_next;

    logic               active;
    sphc_pkg::phase_t   phase_sel;
    sphc_pkg::elapsed_t elapsed_inc;
    logic               step_due;
    sphc_pkg::pos_t     pos_step;
    sphc_pkg::pos_t     sw_pos;
    sphc_pkg::pos_t     target;
    logic               pulse;

    // Homing runs in phases one to four.
    assign active = (phase_reg == sphc_pkg::PH_AIM) || (phase_reg == sphc_pkg::PH_SEEK) ||
                    (phase_reg == sphc_pkg::PH_LOAD) || (phase_reg == sphc_pkg::PH_TARGET);
    assign phase_sel = active ? phase_reg : sphc_pkg::PH_IDLE;

    assign status.active = active;
    assign status.aiming = (phase_reg == sphc_pkg::PH_AIM);
    assign status.homed  = homed_reg;

    // Tick counter saturates at two to the period width.
    assign elapsed_inc = elapsed_reg[sphc_pkg::PERIOD_W] ? elapsed_reg
                                                         : elapsed_reg + 1'b1;
    assign step_due = (period_reg != '0) && (elapsed_inc > {1'b0, period_reg});
    assign pos_step = dir_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
    assign sw_pos   = sphc_pkg::pos_from32(cfg.switch_position);
    assign target   = sphc_pkg::pos_from32(cfg.calib_target);

    // Per-item update.
    always_comb
    begin
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        pos_next     = pos_reg;
        dir_next     = dir_reg;
        phase_next   = phase_reg;
        homed_next   = homed_reg;
        pulse        = 1'b0;
        case (item.op)
            sphc_pkg::OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                case (phase_sel)
                    sphc_pkg::PH_AIM:
                    begin
                        dir_next    = sphc_pkg::aim_dir(pos_reg, target, dir_reg);
                        period_next = new_period;
                        phase_next  = sphc_pkg::PH_SEEK;
                    end
                    sphc_pkg::PH_SEEK:
                    begin
                        if (step_due)
                        begin
                            pos_next     = pos_step;
                            elapsed_next = '0;
                            pulse        = 1'b1;
                        end
                        if (item.switch_level)
                            phase_next = sphc_pkg::PH_LOAD;
                    end
                    sphc_pkg::PH_LOAD:
                    begin
                        pos_next   = sw_pos;
                        dir_next   = sphc_pkg::aim_dir(sw_pos, target, dir_reg);
                        phase_next = sphc_pkg::PH_TARGET;
                    end
                    sphc_pkg::PH_TARGET:
                    begin
                        // Target reached: finish without an extra step.
                        if (pos_reg == target)
                        begin
                            phase_next  = sphc_pkg::PH_IDLE;
                            homed_next  = 1'b1;
                            period_next = '0;
                        end
                        else if (step_due)
                        begin
                            pos_next     = pos_step;
                            elapsed_next = '0;
                            pulse        = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (step_due)
                        begin
                            pos_next     = pos_step;
                            elapsed_next = '0;
                            pulse        = 1'b1;
                        end
                    end
                endcase
            end
            sphc_pkg::OP_SET_SPEED:
            begin
                if (!active)
                    period_next = new_period;
            end
            sphc_pkg::OP_SET_DIR:
            begin
                if (!active)
                    dir_next = item.direction;
            end
            sphc_pkg::OP_HOME:
            begin
                if (!active)
                begin
                    phase_next   = sphc_pkg::PH_AIM;
                    elapsed_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result reflects the state after the item.
    assign result.step_pulse    = pulse;
    assign result.dir_level     = dir_next;
    assign result.position      = sphc_pkg::OUT_POS_W'(pos_next);
    assign result.homing_active = (phase_next == sphc_pkg::PH_AIM) ||
                                  (phase_next == sphc_pkg::PH_SEEK) ||
                                  (phase_next == sphc_pkg::PH_LOAD) ||
                                  (phase_next == sphc_pkg::PH_TARGET);
    assign result.homing_done   = homed_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= '0;
            elapsed_reg <= '0;
            pos_reg     <= '0;
            dir_reg     <= 1'b0;
            phase_reg   <= sphc_pkg::PH_IDLE;
            homed_reg   <= 1'b0;
        end
        else if (commit)
        begin
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
            pos_reg     <= pos_next;
            dir_reg     <= dir_next;
            phase_reg   <= phase_next;
            homed_reg   <= homed_next;
        end
    end

endmodule

@@ rtl/stepper_pulse_homing_controller_top.sv @@
// A speed item, or the tick that starts a homing run, passes from accept through the decode
// state and the period divider, one quotient bit per cycle (36 bits), to the result register.
// Every other item passes from decode straight to the result register. A result is held
// back while the output is full. One item at a time: the next is accepted after the commit.
// Reset (rst_n, asynchronous, active low) stops the motor, zeroes position, direction,
// homing phase and done flag, and loads the register defaults.
`include "stepper_pulse_homing_controller_top_defines.svh"

module stepper_pulse_homing_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    // Command and tick items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // speed_cmd[23:0], direction[24], switch_level[25], zero
    input  logic [1:0]  s_tuser,  // op[1:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // step_pulse[0], dir_level[1], position[33:2],
                                  // homing_active[34], homing_done[35], zero
);

    sphc_pkg::seq_state_t state_reg, state_next;
    sphc_pkg::cfg_t       cfg_reg;
    sphc_pkg::item_t      item_reg;
    sphc_pkg::period_t    period_res_reg;
    sphc_pkg::result_t    out_reg;
    logic                 m_valid_reg;

    sphc_pkg::status_t            status;
    sphc_pkg::result_t            result;
    sphc_pkg::period_t            div_period;
    logic                         div_done;
    logic                         div_start;
    logic                         commit;
    logic                         need_div;
    logic                         out_free;
    logic [sphc_pkg::SPEED_W-1:0] mag;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_deg   <= sphc_pkg::SPD_W'(256);
            cfg_reg.switch_position <= '0;
            cfg_reg.calib_target    <= '0;
            cfg_reg.calib_speed     <= sphc_pkg::CAL_W'(2560);
        end
        else if (cfg_we)
        begin
            case (sphc_pkg::cfg_idx_t'(cfg_addr))
                sphc_pkg::REG_STEPS_PER_DEG:
                    cfg_reg.steps_per_deg <= cfg_data[sphc_pkg::SPD_W-1:0];
                sphc_pkg::REG_SWITCH_POS:
                    cfg_reg.switch_position <= cfg_data;
                sphc_pkg::REG_CALIB_TARGET:
                    cfg_reg.calib_target <= cfg_data;
                sphc_pkg::REG_CALIB_SPEED:
                    cfg_reg.calib_speed <= cfg_data[sphc_pkg::CAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op           <= sphc_pkg::op_t'(s_tuser);
            item_reg.speed_cmd    <= s_tdata[23:0];
            item_reg.direction    <= s_tdata[24];
            item_reg.switch_level <= s_tdata[25];
        end
    end

    // A period is needed for an accepted speed command and for the aiming tick.
    assign need_div = ((item_reg.op == sphc_pkg::OP_SET_SPEED) && !status.active) ||
                      ((item_reg.op == sphc_pkg::OP_TICK) && status.aiming);
    assign out_free = !m_valid_reg || m_tready;

    // Speed magnitude, or the homing speed on the aiming tick.
    always_comb
    begin
        if (item_reg.op == sphc_pkg::OP_SET_SPEED)
            mag = item_reg.speed_cmd[sphc_pkg::SPEED_W-1] ? (~item_reg.speed_cmd + 1'b1)
                                                          : item_reg.speed_cmd;
        else
            mag = sphc_pkg::SPEED_W'(cfg_reg.calib_speed);
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sphc_pkg::SQ_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            sphc_pkg::SQ_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = sphc_pkg::SQ_DECODE;
            end
            sphc_pkg::SQ_DECODE:
            begin
                if (need_div)
                begin
                    div_start  = 1'b1;
                    state_next = sphc_pkg::SQ_DIVIDE;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = sphc_pkg::SQ_IDLE;
                end
                else
                    state_next = sphc_pkg::SQ_WRITE;
            end
            sphc_pkg::SQ_DIVIDE:
            begin
                if (div_done)
                    state_next = sphc_pkg::SQ_WRITE;
            end
            sphc_pkg::SQ_WRITE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = sphc_pkg::SQ_IDLE;
                end
            end
            default:
                state_next = sphc_pkg::SQ_IDLE;
        endcase
    end

    // Hold the computed period until the item commits.
    always_ff @(posedge clk)
    begin
        if (div_done)
            period_res_reg <= div_period;
    end

    sphc_period u_period (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start),
        .mag           (mag),
        .steps_per_deg (cfg_reg.steps_per_deg),
        .done          (div_done),
        .period        (div_period)
    );

    sphc_motion u_motion (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .item       (item_reg),
        .new_period (period_res_reg),
        .cfg        (cfg_reg),
        .status     (status),
        .result     (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (commit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_reg <= result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.homing_done, out_reg.homing_active, out_reg.position,
                       out_reg.dir_level, out_reg.step_pulse};

    // Checks on the sequencer and the homing flag.
    `SPHC_ASSERT_IMP(a_commit_slot_free, commit, out_free, "result overwrote a waiting item")
    `SPHC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item accepted")
    `SPHC_ASSERT_NEXT(a_homed_sticky, status.homed, status.homed, "homing done flag dropped")

endmodule

@@ tb/stepper_motion_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the stepper pulse and homing controller testbench.
// Tracks register writes, predicts each result and compares the result stream.
// Depends on sphc_pkg for the operation, register index and homing phase codes.
module stepper_motion_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // speed_cmd[23:0], direction[24], switch_level[25], zero
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // step_pulse[0], dir_level[1], position[33:2],
                                   // homing_active[34], homing_done[35], zero
    output int          mismatches,
    output int          outstanding
);

    localparam logic [32:0] ELAPSED_CAP  = 33'h1_0000_0000;
    localparam logic [63:0] TICK_SCALE   = 64'd1000000 << 16;
    localparam logic [63:0] PERIOD_LIMIT = 64'hFFFF_FFFF;

    // Local copies of the configuration registers.
    logic [23:0] steps_per_deg;
    logic [31:0] switch_pos;
    logic [31:0] target_pos;
    logic [15:0] calib_speed;

    // Motion state as the block should hold it.
    logic [31:0]       period;
    logic [32:0]       elapsed;
    logic [31:0]       position;
    logic              dir;
    sphc_pkg::phase_t  phase;
    logic              homed;

    sphc_pkg::result_t step_outcomes[$];
    int                bad_count = 0;
    int                waiting = 0;

    assign mismatches  = bad_count;
    assign outstanding = waiting;

    // Ticks per step for a speed magnitude; zero means the motor stands still.
    function automatic logic [31:0] ticks_per_step(input logic [23:0] mag);
        logic [63:0] prod;
        logic [63:0] quot;
        prod = 64'(mag) * 64'(steps_per_deg);
        if (prod == 64'd0)
            return 32'd0;
        quot = TICK_SCALE / prod;
        if (quot > PERIOD_LIMIT)
            quot = PERIOD_LIMIT;
        if (quot == 64'd0)
            quot = 64'd1;
        return quot[31:0];
    endfunction

    // Turn toward the homing target; standing on it keeps the direction.
    function automatic void face_target();
        if ($signed(position) > $signed(target_pos))
            dir = 1'b0;
        else if ($signed(position) < $signed(target_pos))
            dir = 1'b1;
    endfunction

    // Step once the elapsed count has passed a nonzero period.
    function automatic logic step_if_due();
        if (period != 32'd0 && elapsed > {1'b0, period})
        begin
            position = dir ? position + 32'd1 : position - 32'd1;
            elapsed  = 33'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted item to the motion state and queue its result.
    task automatic advance_motion(input sphc_pkg::op_t op, input logic [23:0] spd,
                                  input logic new_dir, input logic switch_closed);
        logic              active;
        logic              pulse;
        logic [23:0]       mag;
        sphc_pkg::result_t res;
        active = (phase != sphc_pkg::PH_IDLE);
        pulse  = 1'b0;
        mag    = spd[23] ? ~spd + 24'd1 : spd;
        case (op)
            sphc_pkg::OP_TICK:
            begin
                if (elapsed < ELAPSED_CAP)
                    elapsed = elapsed + 33'd1;
                case (phase)
                    sphc_pkg::PH_AIM:
                    begin
                        face_target();
                        period = ticks_per_step(24'(calib_speed));
                        phase  = sphc_pkg::PH_SEEK;
                    end
                    sphc_pkg::PH_SEEK:
                    begin
                        // A due step comes before the switch is looked at.
                        pulse = step_if_due();
                        if (switch_closed)
                            phase = sphc_pkg::PH_LOAD;
                    end
                    sphc_pkg::PH_LOAD:
                    begin
                        position = switch_pos;
                        face_target();
                        phase = sphc_pkg::PH_TARGET;
                    end
                    sphc_pkg::PH_TARGET:
                    begin
                        if (position == target_pos)
                        begin
                            phase  = sphc_pkg::PH_IDLE;
                            homed  = 1'b1;
                            period = 32'd0;
                        end
                        else
                        begin
                            pulse = step_if_due();
                        end
                    end
                    default:
                        pulse = step_if_due();
                endcase
            end
            sphc_pkg::OP_SET_SPEED:
            begin
                if (!active)
                    period = ticks_per_step(mag);
            end
            sphc_pkg::OP_SET_DIR:
            begin
                if (!active)
                    dir = new_dir;
            end
            sphc_pkg::OP_HOME:
            begin
                if (!active)
                begin
                    phase   = sphc_pkg::PH_AIM;
                    elapsed = 33'd0;
                end
            end
            default:
            begin
            end
        endcase
        res.step_pulse    = pulse;
        res.dir_level     = dir;
        res.position      = position;
        res.homing_active = (phase != sphc_pkg::PH_IDLE);
        res.homing_done   = homed;
        step_outcomes.push_back(res);
    endtask

    // Report one field that differs from its prediction.
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            bad_count++;
        end
    endtask

    // Follow writes, predict on input items and compare on result items.
    always @(posedge clk or negedge rst_n)
    begin : tracker
        sphc_pkg::result_t want;
        if (!rst_n)
        begin
            steps_per_deg = 24'd256;
            switch_pos    = 32'd0;
            target_pos    = 32'd0;
            calib_speed   = 16'd2560;
            period        = 32'd0;
            elapsed       = 33'd0;
            position      = 32'd0;
            dir           = 1'b0;
            phase         = sphc_pkg::PH_IDLE;
            homed         = 1'b0;
            step_outcomes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (sphc_pkg::cfg_idx_t'(cfg_addr))
                    sphc_pkg::REG_STEPS_PER_DEG: steps_per_deg = cfg_data[23:0];
                    sphc_pkg::REG_SWITCH_POS:    switch_pos    = cfg_data;
                    sphc_pkg::REG_CALIB_TARGET:  target_pos    = cfg_data;
                    sphc_pkg::REG_CALIB_SPEED:   calib_speed   = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                advance_motion(sphc_pkg::op_t'(s_tuser), s_tdata[23:0], s_tdata[24],
                               s_tdata[25]);
            if (m_tvalid && m_tready)
            begin
                if (step_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h",
                             $time, m_tdata);
                    bad_count++;
                end
                else
                begin
                    want = step_outcomes.pop_front();
                    check_field("step_pulse", 32'(want.step_pulse), 32'(m_tdata[0]));
                    check_field("dir_level", 32'(want.dir_level), 32'(m_tdata[1]));
                    check_field("position", want.position, m_tdata[33:2]);
                    check_field("homing_active", 32'(want.homing_active),
                                32'(m_tdata[34]));
                    check_field("homing_done", 32'(want.homing_done), 32'(m_tdata[35]));
                end
            end
        end
        waiting = step_outcomes.size();
    end

endmodule

@@ tb/stepper_pulse_homing_controller_top_tb.sv @@
`timescale 1ns / 100ps
// Top of the stepper pulse and homing controller testbench: clock, reset,
// register writes, item stimulus, result back-pressure and the final verdict.
// Depends on sphc_pkg, the controller RTL and stepper_motion_checker.
module stepper_pulse_homing_controller_top_tb;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 50;
    localparam int PHASE_ITEMS  = 185;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // speed_cmd[23:0], direction[24], switch_level[25], zero
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // step_pulse[0], dir_level[1], position[33:2],
                            // homing_active[34], homing_done[35], zero
    int          mismatches;
    int          outstanding;
    int          quiet_cycles = 0;
    int          send_calm = 0;

    stepper_pulse_homing_controller_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stepper_motion_checker motion_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Free-running 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // End the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Idle cycles before the next item, with runs of back-to-back items now and then.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(8, 30);
        return $urandom_range(0, 12);
    endfunction

    // Result side: random stalls, plus one long hold-off that backs up the block.
    initial
    begin : result_sink
        int gap;
        int taken;
        int calm;
        taken    = 0;
        calm     = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(calm);
            if (taken == HOLD_AFTER)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            taken++;
        end
    end

    // Offer one item after a random gap and wait until the block takes it.
    task automatic send_item(input sphc_pkg::op_t op, input logic [23:0] spd,
                             input logic new_dir, input logic switch_closed);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, switch_closed, new_dir, spd};
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
    endtask

    // Stop offering items and wait until every predicted result has come back.
    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input sphc_pkg::cfg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Load a full register setting while the block is idle.
    task automatic load_settings(input logic [23:0] spd_per_deg, input logic [31:0] sw_pos,
                                 input logic [31:0] target, input logic [15:0] cal_spd);
        settle_block();
        write_reg(sphc_pkg::REG_STEPS_PER_DEG, 32'(spd_per_deg));
        write_reg(sphc_pkg::REG_SWITCH_POS, sw_pos);
        write_reg(sphc_pkg::REG_CALIB_TARGET, target);
        write_reg(sphc_pkg::REG_CALIB_SPEED, 32'(cal_spd));
    endtask

    // Mostly ticks, so that steps and homing runs get far; commands mixed in.
    task automatic random_items(input int count);
        sphc_pkg::op_t op;
        logic [23:0]   mag;
        logic [23:0]   spd;
        int            pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                op = sphc_pkg::OP_TICK;
            else if (pick < 82)
                op = sphc_pkg::OP_SET_SPEED;
            else if (pick < 92)
                op = sphc_pkg::OP_SET_DIR;
            else
                op = sphc_pkg::OP_HOME;
            // Speeds spread over many decades, with some stops and raw bit patterns.
            case ($urandom_range(0, 9))
                0: spd = 24'd0;
                1, 2: spd = 24'($urandom);
                default:
                begin
                    mag = 24'($urandom_range(1, 1 << $urandom_range(0, 16)));
                    spd = ($urandom_range(0, 1) == 1) ? ~mag + 24'd1 : mag;
                end
            endcase
            send_item(op, spd, 1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
        end
    endtask

    initial
    begin : stimulus
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = 2'd0;
        cfg_data = 32'd0;
        s_tvalid = 1'b0;
        s_tdata  = 32'd0;
        s_tuser  = 2'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers: speed extremes, then a homing run already on target.
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b1);
        send_item(sphc_pkg::OP_SET_SPEED, 24'hFFFFFF, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_SET_SPEED, 24'h800000, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_SET_SPEED, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_HOME, 24'd0, 1'b0, 1'b0);
        // Commands and a second start during homing must be ignored.
        send_item(sphc_pkg::OP_SET_SPEED, 24'h7FFFFF, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_SET_DIR, 24'd0, 1'b1, 1'b0);
        send_item(sphc_pkg::OP_HOME, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b1);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b1);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);

        // Smallest gearing: the slowest speed saturates the period.
        load_settings(24'd1, 32'd0, 32'd0, 16'd2560);
        send_item(sphc_pkg::OP_SET_SPEED, 24'd1, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_SET_SPEED, 24'h7FFFFF, 1'b0, 1'b0);

        // Largest gearing: a quotient of zero becomes a period of one, and the
        // elapsed count built up while stopped lets the first tick step at once.
        load_settings(24'hFFFFFF, 32'd0, 32'd0, 16'd2560);
        send_item(sphc_pkg::OP_SET_DIR, 24'd0, 1'b1, 1'b0);
        send_item(sphc_pkg::OP_SET_SPEED, 24'h7FFFFF, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_SET_DIR, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_SET_SPEED, 24'd0, 1'b0, 1'b0);
        send_item(sphc_pkg::OP_TICK, 24'd0, 1'b0, 1'b0);

        // Random phases under several settings; homing runs stay short.
        load_settings(24'h100000, 32'd5, 32'hFFFF_FFFD, 16'hFFFF);
        random_items(PHASE_ITEMS);
        // Homing ends next to the top of the position range so that it wraps.
        load_settings(24'hFFFFFF, 32'h7FFF_FFFC, 32'h7FFF_FFFF, 16'h4000);
        random_items(PHASE_ITEMS);
        // Slowest gearing and homing speed; switch and target at the bottom.
        load_settings(24'd1, 32'h8000_0000, 32'h8000_0000, 16'd1);
        random_items(PHASE_ITEMS);
        load_settings(24'h012345, 32'h8000_0003, 32'h8000_0000, 16'h8000);
        random_items(PHASE_ITEMS);
        load_settings(24'h800000, 32'hFFFF_FFEC, 32'd12, 16'h1000);
        random_items(PHASE_ITEMS);

        settle_block();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
